// File: rtl/core/clr_pkg.sv
// Package with the widths, codes and shared types of the clip-reject line rasterizer.
`default_nettype none

package clr_pkg;

	// Coordinate and field widths.
	localparam int COORD_BITS  = 12;
	localparam int IN_COORD_W  = COORD_BITS + 1;
	localparam int ERR_W       = COORD_BITS + 1;
	localparam int LEFT_W      = COORD_BITS + 1;
	localparam int PITCH_W     = COORD_BITS + 1;
	localparam int BASE_W      = 24;
	localparam int ADDR_W      = 25;
	localparam int COLOR_W     = 16;
	localparam int PROD_W      = COORD_BITS + PITCH_W;

	// Configuration port.
	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 24;

	localparam logic [CFG_INDEX_W-1:0] REG_PITCH       = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_BASE        = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_CLIP_LEFT   = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_CLIP_TOP    = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_CLIP_RIGHT  = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] REG_CLIP_BOTTOM = 3'd5;

	// Reset values of the configuration registers.
	localparam logic [PITCH_W-1:0]    PITCH_RESET     = PITCH_W'(1 << (COORD_BITS - 2));
	localparam logic [BASE_W-1:0]     BASE_RESET      = '0;
	localparam logic [COORD_BITS-1:0] CLIP_LOW_RESET  = '0;
	localparam logic [COORD_BITS-1:0] CLIP_HIGH_RESET = '1;

	// Command codes.
	localparam logic CMD_STEP  = 1'b0;
	localparam logic CMD_START = 1'b1;

	// Configuration register set.
	typedef struct packed {
		logic [PITCH_W-1:0]    pitch;
		logic [BASE_W-1:0]     base;
		logic [COORD_BITS-1:0] clip_left;
		logic [COORD_BITS-1:0] clip_top;
		logic [COORD_BITS-1:0] clip_right;
		logic [COORD_BITS-1:0] clip_bottom;
	} cfg_t;

	// One command word as held in the input register.
	typedef struct packed {
		logic                  cmd;
		logic [IN_COORD_W-1:0] x_start;
		logic [IN_COORD_W-1:0] y_start;
		logic [IN_COORD_W-1:0] x_end;
		logic [IN_COORD_W-1:0] y_end;
		logic [COLOR_W-1:0]    color;
	} line_cmd_t;

	// Line parameters derived from a start command.
	typedef struct packed {
		logic                  accept;
		logic [COORD_BITS-1:0] cur_x;
		logic [COORD_BITS-1:0] cur_y;
		logic [COORD_BITS-1:0] abs_dx;
		logic [COORD_BITS-1:0] abs_dy;
		logic [COORD_BITS-1:0] major_len;
		logic                  x_neg;
		logic                  y_neg;
		logic [COLOR_W-1:0]    color;
	} setup_t;

	// One pixel write word.
	typedef struct packed {
		logic [ADDR_W-1:0]  address;
		logic [COLOR_W-1:0] color;
		logic               last;
	} pixel_t;

endpackage

`default_nettype wire

// File: rtl/core/clr_if.sv
// Valid/ready channel interfaces for line commands and pixel writes.
`default_nettype none

interface clr_cmd_if;
	import clr_pkg::*;

	logic                  valid;
	logic                  ready;
	logic                  cmd;
	logic [IN_COORD_W-1:0] x_start;
	logic [IN_COORD_W-1:0] y_start;
	logic [IN_COORD_W-1:0] x_end;
	logic [IN_COORD_W-1:0] y_end;
	logic [COLOR_W-1:0]    color;

	modport source (output valid, cmd, x_start, y_start, x_end, y_end, color, input ready);
	modport sink   (input valid, cmd, x_start, y_start, x_end, y_end, color, output ready);
endinterface

interface clr_pixel_if;
	import clr_pkg::*;

	logic               valid;
	logic               ready;
	logic [ADDR_W-1:0]  pixel_address;
	logic [COLOR_W-1:0] pixel_color;
	logic               last_pixel;

	modport source (output valid, pixel_address, pixel_color, last_pixel, input ready);
	modport sink   (input valid, pixel_address, pixel_color, last_pixel, output ready);
endinterface

`default_nettype wire

// File: rtl/core/clr_cfg_regs.sv
// Configuration register file of the line rasterizer.
`default_nettype none

module clr_cfg_regs (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_write,
	input  wire logic [clr_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [clr_pkg::CFG_DATA_W-1:0]  cfg_data,
	output clr_pkg::cfg_t                        cfg
);
	import clr_pkg::*;

	cfg_t cfg_q;

	// Register writes, decoded by index; unknown indexes are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pitch       <= PITCH_RESET;
			cfg_q.base        <= BASE_RESET;
			cfg_q.clip_left   <= CLIP_LOW_RESET;
			cfg_q.clip_top    <= CLIP_LOW_RESET;
			cfg_q.clip_right  <= CLIP_HIGH_RESET;
			cfg_q.clip_bottom <= CLIP_HIGH_RESET;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_PITCH:       cfg_q.pitch       <= cfg_data[PITCH_W-1:0];
				REG_BASE:        cfg_q.base        <= cfg_data[BASE_W-1:0];
				REG_CLIP_LEFT:   cfg_q.clip_left   <= cfg_data[COORD_BITS-1:0];
				REG_CLIP_TOP:    cfg_q.clip_top    <= cfg_data[COORD_BITS-1:0];
				REG_CLIP_RIGHT:  cfg_q.clip_right  <= cfg_data[COORD_BITS-1:0];
				REG_CLIP_BOTTOM: cfg_q.clip_bottom <= cfg_data[COORD_BITS-1:0];
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

// File: rtl/core/clr_line_setup.sv
// Clip test and delta setup for a start command.
`default_nettype none

module clr_line_setup (
	input  clr_pkg::line_cmd_t item,
	input  clr_pkg::cfg_t      cfg,
	output clr_pkg::setup_t    setup
);
	import clr_pkg::*;

	logic signed [IN_COORD_W-1:0] x0, y0, x1, y1;
	logic signed [IN_COORD_W-1:0] lo_x, hi_x, lo_y, hi_y;
	logic signed [IN_COORD_W-1:0] dx, dy;
	logic [IN_COORD_W-1:0]        mag_dx, mag_dy;
	logic                         in0, in1;

	always_comb begin
		x0   = $signed(item.x_start);
		y0   = $signed(item.y_start);
		x1   = $signed(item.x_end);
		y1   = $signed(item.y_end);
		lo_x = $signed({1'b0, cfg.clip_left});
		hi_x = $signed({1'b0, cfg.clip_right});
		lo_y = $signed({1'b0, cfg.clip_top});
		hi_y = $signed({1'b0, cfg.clip_bottom});

		// Both endpoints must lie inside the inclusive clip rectangle.
		in0 = (x0 >= lo_x) && (x0 <= hi_x) && (y0 >= lo_y) && (y0 <= hi_y);
		in1 = (x1 >= lo_x) && (x1 <= hi_x) && (y1 >= lo_y) && (y1 <= hi_y);

		// For an accepted line both endpoints are non-negative, so the deltas fit.
		dx     = x1 - x0;
		dy     = y1 - y0;
		mag_dx = dx[IN_COORD_W-1] ? IN_COORD_W'(-dx) : IN_COORD_W'(dx);
		mag_dy = dy[IN_COORD_W-1] ? IN_COORD_W'(-dy) : IN_COORD_W'(dy);

		setup.accept    = in0 && in1;
		setup.cur_x     = item.x_start[COORD_BITS-1:0];
		setup.cur_y     = item.y_start[COORD_BITS-1:0];
		setup.abs_dx    = mag_dx[COORD_BITS-1:0];
		setup.abs_dy    = mag_dy[COORD_BITS-1:0];
		setup.major_len = (mag_dx[COORD_BITS-1:0] > mag_dy[COORD_BITS-1:0]) ?
			mag_dx[COORD_BITS-1:0] : mag_dy[COORD_BITS-1:0];
		setup.x_neg     = dx[IN_COORD_W-1];
		setup.y_neg     = dy[IN_COORD_W-1];
		setup.color     = item.color;
	end

endmodule

`default_nettype wire

// File: rtl/core/clr_dda_core.sv
// Line state, error-accumulator stepping and the registered pixel write word.
`default_nettype none

module clr_dda_core (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   fire,
	input  wire logic   advance,
	input  wire logic   cmd,
	input  clr_pkg::setup_t setup,
	input  clr_pkg::cfg_t   cfg,
	output clr_pkg::pixel_t pix,
	output logic            pix_valid
);
	import clr_pkg::*;

	logic                  active_q;
	logic [COORD_BITS-1:0] cur_x_q, cur_y_q;
	logic [ERR_W-1:0]      x_err_q, y_err_q;
	logic [COORD_BITS-1:0] abs_dx_q, abs_dy_q, major_q;
	logic                  x_neg_q, y_neg_q;
	logic [LEFT_W-1:0]     left_q;
	logic [COLOR_W-1:0]    color_q;

	pixel_t pix_s2;
	logic   valid_s2;

	logic                  do_start, do_step;
	logic [ERR_W-1:0]      x_sum, y_sum;
	logic                  x_move, y_move;
	logic [ERR_W-1:0]      x_err_next, y_err_next;
	logic [COORD_BITS-1:0] x_next, y_next;
	logic [PROD_W-1:0]     row_off;
	logic                  is_last;
	pixel_t                pix_next;

	// Step arithmetic on the current line state.
	always_comb begin
		do_start = fire && (cmd == CMD_START);
		do_step  = fire && (cmd == CMD_STEP) && active_q;

		x_sum      = x_err_q + ERR_W'(abs_dx_q);
		y_sum      = y_err_q + ERR_W'(abs_dy_q);
		x_move     = x_sum > ERR_W'(major_q);
		y_move     = y_sum > ERR_W'(major_q);
		x_err_next = x_move ? x_sum - ERR_W'(major_q) : x_sum;
		y_err_next = y_move ? y_sum - ERR_W'(major_q) : y_sum;
		x_next     = !x_move ? cur_x_q : (x_neg_q ? cur_x_q - 1'b1 : cur_x_q + 1'b1);
		y_next     = !y_move ? cur_y_q : (y_neg_q ? cur_y_q - 1'b1 : cur_y_q + 1'b1);
		is_last    = left_q <= LEFT_W'(1);

		// Address is base + y * pitch + x, wrapped to the address width.
		row_off          = PROD_W'(cur_y_q) * PROD_W'(cfg.pitch);
		pix_next.address = ADDR_W'(row_off) + ADDR_W'(cfg.base) + ADDR_W'(cur_x_q);
		pix_next.color   = color_q;
		pix_next.last    = is_last;
	end

	// Active flag: set by an accepted start, cleared by a rejected start or the last step.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
		end else if (do_start) begin
			active_q <= setup.accept;
		end else if (do_step && is_last) begin
			active_q <= 1'b0;
		end
	end

	// Line state registers.
	always_ff @(posedge clk) begin
		if (do_start && setup.accept) begin
			cur_x_q  <= setup.cur_x;
			cur_y_q  <= setup.cur_y;
			x_err_q  <= ERR_W'(setup.abs_dx);
			y_err_q  <= ERR_W'(setup.abs_dy);
			abs_dx_q <= setup.abs_dx;
			abs_dy_q <= setup.abs_dy;
			major_q  <= setup.major_len;
			x_neg_q  <= setup.x_neg;
			y_neg_q  <= setup.y_neg;
			left_q   <= LEFT_W'(setup.major_len) + LEFT_W'(1);
			color_q  <= setup.color;
		end else if (do_step) begin
			cur_x_q <= x_next;
			cur_y_q <= y_next;
			x_err_q <= x_err_next;
			y_err_q <= y_err_next;
			left_q  <= is_last ? '0 : left_q - LEFT_W'(1);
		end
	end

	// Output register valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= do_step;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (do_step) begin
			pix_s2 <= pix_next;
		end
	end

	assign pix       = pix_s2;
	assign pix_valid = valid_s2;

endmodule

`default_nettype wire

// File: rtl/core/clip_reject_line_rasterizer_top.sv
// Top level of the clip-reject line rasterizer.
`default_nettype none

// Clip-reject DDA line rasterizer. A start word loads two endpoints and a color;
// unless both endpoints lie inside the inclusive clip rectangle the line is
// dropped. While a line is active, each step word yields one pixel write word
// (base + y * pitch + x, color, last flag), d + 1 of them for a line whose
// major length is d. A command word is captured in an input register when
// accepted and, as the pipeline advances, goes through the line state update,
// which loads the output register that presents its pixel word; one word is
// accepted every cycle as long as the pixel output is taken. The step path is
// bounded by the y * pitch multiply and address add feeding the output
// register. Configuration registers must be written only while no command is
// in flight; the block itself does not enforce this.
module clip_reject_line_rasterizer_top (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_write,
	input  wire logic [clr_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [clr_pkg::CFG_DATA_W-1:0]  cfg_data,
	clr_cmd_if.sink                              line_cmd,
	clr_pixel_if.source                          pixel
);
	import clr_pkg::*;

	cfg_t      cfg;
	line_cmd_t item_s1;
	logic      valid_s1;
	logic      advance;
	logic      fire;
	setup_t    setup;
	pixel_t    pix;
	logic      pix_valid;

	// Pipeline moves when the output register is empty or being drained.
	assign advance        = !pix_valid || pixel.ready;
	assign line_cmd.ready = !valid_s1 || advance;
	assign fire           = valid_s1 && advance;

	// Input register valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (line_cmd.ready) begin
			valid_s1 <= line_cmd.valid;
		end
	end

	// Input register payload.
	always_ff @(posedge clk) begin
		if (line_cmd.valid && line_cmd.ready) begin
			item_s1.cmd     <= line_cmd.cmd;
			item_s1.x_start <= line_cmd.x_start;
			item_s1.y_start <= line_cmd.y_start;
			item_s1.x_end   <= line_cmd.x_end;
			item_s1.y_end   <= line_cmd.y_end;
			item_s1.color   <= line_cmd.color;
		end
	end

	clr_cfg_regs u_cfg_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	clr_line_setup u_line_setup (
		.item  (item_s1),
		.cfg   (cfg),
		.setup (setup)
	);

	clr_dda_core u_dda_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (fire),
		.advance   (advance),
		.cmd       (item_s1.cmd),
		.setup     (setup),
		.cfg       (cfg),
		.pix       (pix),
		.pix_valid (pix_valid)
	);

	// Pixel output drive.
	assign pixel.valid         = pix_valid;
	assign pixel.pixel_address = pix.address;
	assign pixel.pixel_color   = pix.color;
	assign pixel.last_pixel    = pix.last;

	// A new pixel word only follows a step word leaving the input register.
	a_pixel_from_step: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(pixel.valid) |-> $past(valid_s1 && item_s1.cmd == CMD_STEP))
		else $error("pixel word appeared without a step word");

	// A start word never yields a pixel word.
	a_start_no_pixel: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && item_s1.cmd == CMD_START) |=> !pixel.valid)
		else $error("start word produced a pixel word");

	// With the output register empty, the block always takes a new word.
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!pixel.valid |-> line_cmd.ready)
		else $error("input stalled with an empty output register");

endmodule

`default_nettype wire

// File: tb/tb_clip_reject_line_rasterizer_top.sv
// Self-checking testbench for the clip-reject line rasterizer with a DDA predictor.
`timescale 1ns / 1ps

module tb_clip_reject_line_rasterizer_top;
	import clr_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_CYCLES = 8;

	logic clk;
	logic arst_n;
	logic cfg_write;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	clr_cmd_if cmd_ch ();
	clr_pixel_if pix_ch ();

	clip_reject_line_rasterizer_top u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.line_cmd (cmd_ch),
		.pixel    (pix_ch)
	);

	// Register copies kept in step with every configuration write.
	logic [PITCH_W-1:0] cfg_pitch;
	logic [BASE_W-1:0] cfg_base;
	logic [COORD_BITS-1:0] win_left, win_top, win_right, win_bottom;

	// Line state of the predictor.
	bit line_active;
	logic [COORD_BITS-1:0] pos_x, pos_y;
	int err_x, err_y, run_dx, run_dy, run_major, dir_x, dir_y, pixels_remaining;
	logic [COLOR_W-1:0] line_color_q;

	// Words waiting to be driven and pixel words waiting to be seen.
	line_cmd_t cmd_words[$];
	pixel_t expected_pixels[$];
	int words_in_flight;

	int sender_idle_pct, receiver_stall_pct;
	int words_accepted, lines_armed, lines_rejected, pixels_checked, mismatches;
	int cycle_count;

	// Clock.
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic bit point_in_window(int x, int y);
		return x >= int'(win_left) && x <= int'(win_right) &&
			y >= int'(win_top) && y <= int'(win_bottom);
	endfunction

	function automatic int clamp_to(int v, int lo, int hi);
		return (v < lo) ? lo : (v > hi) ? hi : v;
	endfunction

	function automatic int iabs(int v);
		return (v < 0) ? -v : v;
	endfunction

	function automatic int full_coord();
		int v;
		v = $urandom_range(0, 8191);
		return v - 4096;
	endfunction

	// Mirror a register write into the predictor's copy.
	function void set_model_reg(logic [CFG_INDEX_W-1:0] idx, int data);
		case (idx)
			REG_PITCH: cfg_pitch = data[PITCH_W-1:0];
			REG_BASE: cfg_base = data[BASE_W-1:0];
			REG_CLIP_LEFT: win_left = data[COORD_BITS-1:0];
			REG_CLIP_TOP: win_top = data[COORD_BITS-1:0];
			REG_CLIP_RIGHT: win_right = data[COORD_BITS-1:0];
			REG_CLIP_BOTTOM: win_bottom = data[COORD_BITS-1:0];
			default: ;
		endcase
	endfunction

	// Work out what one accepted command word produces and advance the line state.
	function void rasterize_word(line_cmd_t w);
		int x0, y0, x1, y1, dx, dy;
		longint unsigned addr;
		pixel_t px;
		if (w.cmd == CMD_START) begin
			x0 = $signed(w.x_start);
			y0 = $signed(w.y_start);
			x1 = $signed(w.x_end);
			y1 = $signed(w.y_end);
			if (!point_in_window(x0, y0) || !point_in_window(x1, y1)) begin
				line_active = 1'b0;
				lines_rejected++;
				return;
			end
			dx = x1 - x0;
			dy = y1 - y0;
			dir_x = (dx > 0) ? 1 : (dx < 0) ? -1 : 0;
			dir_y = (dy > 0) ? 1 : (dy < 0) ? -1 : 0;
			run_dx = iabs(dx);
			run_dy = iabs(dy);
			run_major = (run_dx > run_dy) ? run_dx : run_dy;
			pos_x = x0[COORD_BITS-1:0];
			pos_y = y0[COORD_BITS-1:0];
			// The first accumulation never moves, so it is folded into the load.
			err_x = run_dx;
			err_y = run_dy;
			pixels_remaining = run_major + 1;
			line_color_q = w.color;
			line_active = 1'b1;
			lines_armed++;
		end else if (line_active) begin
			addr = longint'(cfg_base) + longint'(pos_y) * longint'(cfg_pitch) + longint'(pos_x);
			px.address = addr[ADDR_W-1:0];
			px.color = line_color_q;
			px.last = (pixels_remaining <= 1);
			expected_pixels.push_back(px);
			err_x += run_dx;
			err_y += run_dy;
			if (err_x > run_major) begin
				err_x -= run_major;
				pos_x = COORD_BITS'(int'(pos_x) + dir_x);
			end
			if (err_y > run_major) begin
				err_y -= run_major;
				pos_y = COORD_BITS'(int'(pos_y) + dir_y);
			end
			if (pixels_remaining <= 1) begin
				pixels_remaining = 0;
				line_active = 1'b0;
			end else begin
				pixels_remaining--;
			end
		end
	endfunction

	function void post_word(logic c, int x0, int y0, int x1, int y1, int color);
		line_cmd_t w;
		w.cmd = c;
		w.x_start = x0[IN_COORD_W-1:0];
		w.y_start = y0[IN_COORD_W-1:0];
		w.x_end = x1[IN_COORD_W-1:0];
		w.y_end = y1[IN_COORD_W-1:0];
		w.color = color[COLOR_W-1:0];
		cmd_words.push_back(w);
		words_in_flight++;
	endfunction

	function void post_start(int x0, int y0, int x1, int y1, int color);
		post_word(CMD_START, x0, y0, x1, y1, color);
	endfunction

	// Step words carry random content in the fields that they ignore.
	function void post_step();
		post_word(CMD_STEP, full_coord(), full_coord(), full_coord(), full_coord(),
			$urandom_range(0, 65535));
	endfunction

	// Random lines inside the window, plus rejected starts, starts anywhere and stray steps.
	function void queue_random_lines(int target);
		int counted, roll, x0, y0, x1, y1, span, d, steps, k, offset;
		bit window_ok;
		counted = 0;
		window_ok = (win_left <= win_right) && (win_top <= win_bottom);
		while (counted < target) begin
			roll = $urandom_range(0, 99);
			if (window_ok && roll < 72) begin
				// A well-formed line, usually short, drawn to its end or cut short.
				x0 = $urandom_range(0, 9) == 0 ?
					($urandom_range(0, 1) ? int'(win_right) : int'(win_left)) :
					int'($urandom_range(win_right, win_left));
				y0 = $urandom_range(0, 9) == 0 ?
					($urandom_range(0, 1) ? int'(win_bottom) : int'(win_top)) :
					int'($urandom_range(win_bottom, win_top));
				span = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 12) : 8191;
				offset = $urandom_range(0, 2 * span);
				x1 = clamp_to(x0 + offset - span, int'(win_left), int'(win_right));
				offset = $urandom_range(0, 2 * span);
				y1 = clamp_to(y0 + offset - span, int'(win_top), int'(win_bottom));
				d = (iabs(x1 - x0) > iabs(y1 - y0)) ? iabs(x1 - x0) : iabs(y1 - y0);
				post_start(x0, y0, x1, y1, $urandom_range(0, 65535));
				steps = d + 1;
				if (steps > 40)
					steps = $urandom_range(1, 40);
				else if ($urandom_range(0, 99) < 15)
					steps = $urandom_range(1, steps);
				for (k = 0; k < steps; k++)
					post_step();
				counted += 1 + steps;
				if ($urandom_range(0, 99) < 10) begin
					for (k = $urandom_range(1, 3); k > 0; k--) begin
						post_step();
						counted++;
					end
				end
			end else if (roll < 86) begin
				// A start that misses the window by one pixel, or one with endpoints anywhere.
				x0 = full_coord();
				y0 = full_coord();
				x1 = full_coord();
				y1 = full_coord();
				if (window_ok && $urandom_range(0, 1)) begin
					x0 = $urandom_range(win_right, win_left);
					y0 = $urandom_range(win_bottom, win_top);
					x1 = $urandom_range(win_right, win_left);
					y1 = $urandom_range(win_bottom, win_top);
					case ($urandom_range(0, 3))
						0: x1 = int'(win_left) - 1;
						1: x0 = int'(win_right) + 1;
						2: y1 = int'(win_top) - 1;
						default: y0 = int'(win_bottom) + 1;
					endcase
				end
				post_start(x0, y0, x1, y1, $urandom_range(0, 65535));
				counted++;
				for (k = $urandom_range(0, 2); k > 0; k--) begin
					post_step();
					counted++;
				end
			end else begin
				// A start anywhere in the coordinate range, then a few steps.
				post_start(full_coord(), full_coord(), full_coord(), full_coord(),
					$urandom_range(0, 65535));
				counted++;
				for (k = $urandom_range(0, 3); k > 0; k--) begin
					post_step();
					counted++;
				end
			end
		end
	endfunction

	// Write all six registers; only called while nothing is in flight.
	task automatic configure(int pitch, int base, int left, int top, int right, int bottom);
		logic [CFG_INDEX_W-1:0] regs[6];
		int vals[6];
		regs = '{REG_PITCH, REG_BASE, REG_CLIP_LEFT, REG_CLIP_TOP, REG_CLIP_RIGHT,
			REG_CLIP_BOTTOM};
		vals = '{pitch, base, left, top, right, bottom};
		foreach (regs[i]) begin
			@(posedge clk);
			cfg_write <= 1'b1;
			cfg_index <= regs[i];
			cfg_data <= vals[i][CFG_DATA_W-1:0];
			set_model_reg(regs[i], vals[i]);
		end
		@(posedge clk);
		cfg_write <= 1'b0;
	endtask

	// Wait until every word is accepted and every pixel word has arrived.
	task automatic wait_drained();
		while (words_in_flight != 0 || expected_pixels.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Command driver: holds a word until it is taken, with random gaps between words.
	always @(posedge clk or negedge arst_n) begin
		line_cmd_t w;
		if (!arst_n) begin
			cmd_ch.valid <= 1'b0;
			cmd_ch.cmd <= CMD_STEP;
			cmd_ch.x_start <= '0;
			cmd_ch.y_start <= '0;
			cmd_ch.x_end <= '0;
			cmd_ch.y_end <= '0;
			cmd_ch.color <= '0;
		end else begin
			if (cmd_ch.valid && cmd_ch.ready) begin
				w.cmd = cmd_ch.cmd;
				w.x_start = cmd_ch.x_start;
				w.y_start = cmd_ch.y_start;
				w.x_end = cmd_ch.x_end;
				w.y_end = cmd_ch.y_end;
				w.color = cmd_ch.color;
				rasterize_word(w);
				words_accepted++;
				words_in_flight--;
			end
			if (!cmd_ch.valid || cmd_ch.ready) begin
				if (cmd_words.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
					w = cmd_words.pop_front();
					cmd_ch.cmd <= w.cmd;
					cmd_ch.x_start <= w.x_start;
					cmd_ch.y_start <= w.y_start;
					cmd_ch.x_end <= w.x_end;
					cmd_ch.y_end <= w.y_end;
					cmd_ch.color <= w.color;
					cmd_ch.valid <= 1'b1;
				end else begin
					cmd_ch.valid <= 1'b0;
				end
			end
		end
	end

	// Pixel monitor: compares each taken pixel word with the oldest expectation.
	always @(posedge clk or negedge arst_n) begin
		pixel_t exp_px;
		if (!arst_n) begin
			pix_ch.ready <= 1'b0;
		end else begin
			if (pix_ch.valid && pix_ch.ready) begin
				if (expected_pixels.size() == 0) begin
					$error("pixel word with no expectation: address %0h color %0h last %0b",
						pix_ch.pixel_address, pix_ch.pixel_color, pix_ch.last_pixel);
					mismatches++;
				end else begin
					exp_px = expected_pixels.pop_front();
					pixels_checked++;
					if (pix_ch.pixel_address !== exp_px.address) begin
						$error("pixel_address: expected %0h, actual %0h", exp_px.address,
							pix_ch.pixel_address);
						mismatches++;
					end
					if (pix_ch.pixel_color !== exp_px.color) begin
						$error("pixel_color: expected %0h, actual %0h", exp_px.color,
							pix_ch.pixel_color);
						mismatches++;
					end
					if (pix_ch.last_pixel !== exp_px.last) begin
						$error("last_pixel: expected %0b, actual %0b", exp_px.last,
							pix_ch.last_pixel);
						mismatches++;
					end
				end
			end
			pix_ch.ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
		end
	end

	// Watchdog.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles with %0d pixel words outstanding", cycle_count,
				expected_pixels.size());
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// Phase sequencer: register settings, idle patterns and stimulus.
	initial begin
		int phase;
		arst_n <= 1'b0;
		cfg_write <= 1'b0;
		cfg_index <= REG_PITCH;
		cfg_data <= '0;
		sender_idle_pct = 0;
		receiver_stall_pct = 0;
		words_in_flight = 0;
		line_active = 1'b0;
		set_model_reg(REG_PITCH, int'(PITCH_RESET));
		set_model_reg(REG_BASE, int'(BASE_RESET));
		set_model_reg(REG_CLIP_LEFT, int'(CLIP_LOW_RESET));
		set_model_reg(REG_CLIP_TOP, int'(CLIP_LOW_RESET));
		set_model_reg(REG_CLIP_RIGHT, int'(CLIP_HIGH_RESET));
		set_model_reg(REG_CLIP_BOTTOM, int'(CLIP_HIGH_RESET));
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (phase = 0; phase < 9; phase++) begin
			// Idle pattern: none, sender gaps, receiver stalls, then both.
			case (phase % 4)
				0: begin sender_idle_pct = 0; receiver_stall_pct = 0; end
				1: begin sender_idle_pct = 79; receiver_stall_pct = 0; end
				2: begin sender_idle_pct = 0; receiver_stall_pct = 79; end
				default: begin sender_idle_pct = 34; receiver_stall_pct = 34; end
			endcase
			case (phase)
				0: begin
					// Reset settings: step while idle, single points at both corners,
					// rejected starts, a short line, and restarts over an active line.
					post_step();
					post_start(0, 0, 0, 0, 16'hFFFF);
					post_step();
					post_step();
					post_start(4095, 4095, 4095, 4095, 0);
					post_step();
					post_start(-1, 0, 5, 5, 16'h1111);
					post_step();
					post_start(-4096, 4095, 4095, -4096, 16'h8000);
					post_start(0, 0, 3, 1, 16'hA5A5);
					repeat (4) post_step();
					post_start(10, 20, 8, 26, 16'h1234);
					repeat (3) post_step();
					post_start(4095, 0, 0, 4095, 16'h5A5A);
					repeat (2) post_step();
					post_start(0, 0, -1, -1, 16'h7FFF);
					post_step();
					queue_random_lines(200);
				end
				1: begin
					configure(4096, 24'hFFFFFF, 0, 0, 4095, 4095);
					queue_random_lines(200);
				end
				2: begin
					configure(1, 0, 100, 200, 163, 263);
					queue_random_lines(200);
				end
				3: begin
					configure($urandom_range(1, 4096), $urandom_range(0, 24'hFFFFFF),
						$urandom_range(0, 2047), $urandom_range(0, 2047),
						$urandom_range(2047, 4095), $urandom_range(2047, 4095));
					queue_random_lines(200);
				end
				4: begin
					// Zero pitch and a one-column window at the right edge.
					configure(0, 123456, 4095, 0, 4095, 4095);
					queue_random_lines(150);
				end
				5: begin
					// The largest pitch the register holds, with a small window.
					configure(8191, $urandom_range(0, 24'hFFFFFF), 0, 0, 31, 31);
					queue_random_lines(150);
				end
				6: begin
					// Empty window with left beyond right: every start is dropped.
					configure(640, 0, 10, 0, 5, 4095);
					queue_random_lines(40);
				end
				7: begin
					// Empty window with top beyond bottom.
					configure(640, 0, 0, 300, 4095, 299);
					queue_random_lines(40);
				end
				default: begin
					configure(3000, $urandom_range(0, 24'hFFFFFF),
						$urandom_range(0, 4000), $urandom_range(0, 4000),
						$urandom_range(4000, 4095), $urandom_range(4000, 4095));
					queue_random_lines(170);
				end
			endcase
			wait_drained();
		end

		$display("Run covered %0d command words: %0d lines armed, %0d starts rejected.",
			words_accepted, lines_armed, lines_rejected);
		$display("Checked %0d pixel words over nine register settings and four idle patterns.",
			pixels_checked);
		if (mismatches == 0 && expected_pixels.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
